// ===== rtl/core/kernel_svm_classifier_assert.svh =====
// Assertion macros for the kernel SVM classifier.
// Needs nothing else; assertions are left out when SYNTHESIS is defined.
`ifndef KERNEL_SVM_CLASSIFIER_ASSERT_SVH
`define KERNEL_SVM_CLASSIFIER_ASSERT_SVH
`ifndef SYNTHESIS
`define KSVM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kernel_svm_classifier assertion failed");
`define KSVM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kernel_svm_classifier assertion failed");
`else
`define KSVM_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define KSVM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/ksvm_pkg.sv =====
// Shared types, constants and helper functions of the kernel SVM classifier.
// Depends on nothing.
package ksvm_pkg;

  localparam int MAX_VECTORS = 256;
  localparam int IDX_W = 8;
  localparam int CNT_W = 9;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  localparam logic [1:0] KM_LINEAR = 2'd0;
  localparam logic [1:0] KM_POLY = 2'd1;
  localparam logic [1:0] KM_GAUSS = 2'd2;
  localparam logic [1:0] KM_SIGMOID = 2'd3;

  localparam logic [2:0] REG_KERNEL_MODE = 3'd0;
  localparam logic [2:0] REG_GAUSSIAN_GAMMA = 3'd1;
  localparam logic [2:0] REG_POLY_DEGREE = 3'd2;
  localparam logic [2:0] REG_SIGMOID_GAIN = 3'd3;
  localparam logic [2:0] REG_SIGMOID_OFFSET = 3'd4;
  localparam logic [2:0] REG_BIAS_TERM = 3'd5;
  localparam logic [2:0] REG_VECTOR_COUNT = 3'd6;

  localparam logic [30:0] ONE30 = 31'h4000_0000;
  localparam logic [52:0] EXP_LIMIT = 53'd285212672;
  localparam logic [43:0] POW_LIMIT = 44'd8388607;
  localparam logic [46:0] KVAL_MAX = 47'h7FFF_FFFF_FFFF;
  localparam logic signed [47:0] Q24_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] Q24_MIN = 48'sh8000_0000_0000;

  typedef struct packed {
    logic [9:0]  x;
    logic [9:0]  y;
    logic        pos;
    logic [30:0] alpha;
  } entry_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [30:0]        gamma;
    logic [3:0]         degree;
    logic signed [31:0] gain;
    logic signed [31:0] offset;
  } kcfg_t;

  typedef enum logic [3:0] {
    KS_IDLE, KS_PREP, KS_SEL, KS_POLY, KS_ARG, KS_EXPCHK, KS_HMUL, KS_HREC,
    KS_HFIX, KS_SQR, KS_POST, KS_DIVW, KS_DONE
  } kst_t;

  typedef enum logic [3:0] {
    T_IDLE, T_READ, T_KSTART, T_KWAIT, T_MULH, T_MULL, T_ACC, T_BIAS, T_OUT
  } tst_t;

  // Floor of 2^32 / k for the small Horner divisors.
  function automatic logic [31:0] recip(input logic [3:0] k);
    logic [31:0] m;
    case (k)
      4'd2:    m = 32'd2147483648;
      4'd3:    m = 32'd1431655765;
      4'd4:    m = 32'd1073741824;
      4'd5:    m = 32'd858993459;
      4'd6:    m = 32'd715827882;
      4'd7:    m = 32'd613566756;
      4'd8:    m = 32'd536870912;
      4'd9:    m = 32'd477218588;
      4'd10:   m = 32'd429496729;
      default: m = 32'd0;
    endcase
    return m;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    logic signed [47:0] s;
    if (v[48] != v[47]) begin
      s = v[48] ? Q24_MIN : Q24_MAX;
    end else begin
      s = v[47:0];
    end
    return s;
  endfunction

endpackage

// ===== rtl/core/ksvm_store.sv =====
// Support vector store: one synchronous write port and one registered read port.
// Depends on ksvm_pkg.
module ksvm_store (
  input  logic                  clk,
  input  logic                  we,
  input  logic [7:0]            waddr,
  input  ksvm_pkg::entry_t      wdata,
  input  logic                  re,
  input  logic [7:0]            raddr,
  output ksvm_pkg::entry_t      rdata
);
  import ksvm_pkg::*;

  entry_t mem [MAX_VECTORS];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/ksvm_div.sv =====
// Restoring divider, one quotient bit per cycle, 25-bit quotient.
// Depends on ksvm_pkg for style consistency; used by the kernel unit.
module ksvm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [54:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [24:0] quot
);
  import ksvm_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [55:0] rem_r, rem_nxt;
  logic [55:0] den_r, den_nxt;
  logic [24:0] q_r, q_nxt;
  logic [4:0]  cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r <= q_nxt;
    cnt_r <= cnt_nxt;
  end

  always_comb begin
    logic ge;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt = rem_r;
    den_nxt = den_r;
    q_nxt = q_r;
    cnt_nxt = cnt_r;
    ge = rem_r >= den_r;
    if (start) begin
      rem_nxt = {1'b0, dividend};
      den_nxt = {divisor, 24'b0};
      q_nxt = '0;
      cnt_nxt = 5'd24;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - den_r;
      end
      q_nxt = {q_r[23:0], ge};
      den_nxt = den_r >> 1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 5'd1;
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== rtl/core/ksvm_kernel.sv =====
// Kernel evaluation sequencer for one support entry against the query point.
// Depends on ksvm_pkg and ksvm_div.
module ksvm_kernel (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [9:0]      ex,
  input  logic [9:0]      ey,
  input  logic [9:0]      qx,
  input  logic [9:0]      qy,
  input  ksvm_pkg::kcfg_t cfg,
  output logic            done,
  output logic [46:0]     kval
);
  import ksvm_pkg::*;

  kst_t        state_r, state_nxt;
  logic [9:0]  ex_r, ey_r, qx_r, qy_r;
  logic [9:0]  ex_nxt, ey_nxt, qx_nxt, qy_nxt;
  logic [20:0] dot_r, dot_nxt, d2_r, d2_nxt;
  logic [22:0] pw_r, pw_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [52:0] t_r, t_nxt;
  logic        neg_r, neg_nxt;
  logic [29:0] x_r, x_nxt, pr_r, pr_nxt;
  logic [30:0] r_r, r_nxt;
  logic [61:0] qm_r, qm_nxt;
  logic [46:0] kval_r, kval_nxt;

  logic        div_start, div_done;
  logic [54:0] div_dividend;
  logic [31:0] div_divisor;
  logic [24:0] div_q;

  ksvm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= KS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    ex_r <= ex_nxt;
    ey_r <= ey_nxt;
    qx_r <= qx_nxt;
    qy_r <= qy_nxt;
    dot_r <= dot_nxt;
    d2_r <= d2_nxt;
    pw_r <= pw_nxt;
    cnt_r <= cnt_nxt;
    t_r <= t_nxt;
    neg_r <= neg_nxt;
    x_r <= x_nxt;
    pr_r <= pr_nxt;
    r_r <= r_nxt;
    qm_r <= qm_nxt;
    kval_r <= kval_nxt;
  end

  always_comb begin
    logic [19:0]        pxx, pyy;
    logic signed [10:0] dx, dy;
    logic signed [21:0] sqx, sqy, sqs;
    logic [43:0]        pprod;
    logic [51:0]        gt;
    logic signed [53:0] u, ua;
    logic [60:0]        xr;
    logic [29:0]        q0, qf;
    logic [33:0]        qk, rem;
    logic               bump;
    logic [61:0]        rr;

    state_nxt = state_r;
    ex_nxt = ex_r;
    ey_nxt = ey_r;
    qx_nxt = qx_r;
    qy_nxt = qy_r;
    dot_nxt = dot_r;
    d2_nxt = d2_r;
    pw_nxt = pw_r;
    cnt_nxt = cnt_r;
    t_nxt = t_r;
    neg_nxt = neg_r;
    x_nxt = x_r;
    pr_nxt = pr_r;
    r_nxt = r_r;
    qm_nxt = qm_r;
    kval_nxt = kval_r;
    div_start = 1'b0;
    div_dividend = neg_r ? {1'b1, 54'b0} : {r_r, 24'b0};
    div_divisor = {1'b0, ONE30} + {1'b0, r_r};

    pxx = ex_r * qx_r;
    pyy = ey_r * qy_r;
    dx = $signed({1'b0, ex_r}) - $signed({1'b0, qx_r});
    dy = $signed({1'b0, ey_r}) - $signed({1'b0, qy_r});
    sqx = dx * dx;
    sqy = dy * dy;
    sqs = sqx + sqy;
    pprod = pw_r * dot_r;
    gt = cfg.gamma * d2_r;
    u = cfg.gain * $signed({1'b0, dot_r}) + cfg.offset;
    ua = u[53] ? -u : u;
    xr = x_r * r_r;
    q0 = (cnt_r == 4'd1) ? pr_r : qm_r[61:32];
    qk = q0 * cnt_r;
    rem = {4'b0, pr_r} - qk;
    bump = (cnt_r != 4'd1) && (rem >= {30'b0, cnt_r});
    qf = q0 + {29'b0, bump};
    rr = r_r * r_r;

    case (state_r)
      KS_IDLE: begin
        if (start) begin
          ex_nxt = ex;
          ey_nxt = ey;
          qx_nxt = qx;
          qy_nxt = qy;
          state_nxt = KS_PREP;
        end
      end
      KS_PREP: begin
        dot_nxt = {1'b0, pxx} + {1'b0, pyy};
        d2_nxt = sqs[20:0];
        state_nxt = KS_SEL;
      end
      KS_SEL: begin
        case (cfg.mode)
          KM_LINEAR: begin
            kval_nxt = {2'b0, dot_r, 24'b0};
            state_nxt = KS_DONE;
          end
          KM_POLY: begin
            if (cfg.degree <= 4'd1) begin
              kval_nxt = {2'b0, dot_r, 24'b0};
              state_nxt = KS_DONE;
            end else begin
              pw_nxt = {2'b0, dot_r};
              cnt_nxt = 4'd1;
              state_nxt = KS_POLY;
            end
          end
          default: state_nxt = KS_ARG;
        endcase
      end
      KS_POLY: begin
        if (pprod > POW_LIMIT) begin
          kval_nxt = KVAL_MAX;
          state_nxt = KS_DONE;
        end else begin
          pw_nxt = pprod[22:0];
          cnt_nxt = cnt_r + 4'd1;
          if (cnt_r + 4'd1 == cfg.degree) begin
            kval_nxt = {pprod[22:0], 24'b0};
            state_nxt = KS_DONE;
          end
        end
      end
      KS_ARG: begin
        if (cfg.mode == KM_GAUSS) begin
          t_nxt = {1'b0, gt};
          neg_nxt = 1'b0;
        end else begin
          t_nxt = ua[52:0];
          neg_nxt = u[53];
        end
        state_nxt = KS_EXPCHK;
      end
      KS_EXPCHK: begin
        if (t_r >= EXP_LIMIT) begin
          r_nxt = '0;
          state_nxt = KS_POST;
        end else begin
          x_nxt = {t_r[28:0], 1'b0};
          r_nxt = ONE30;
          cnt_nxt = 4'd10;
          state_nxt = KS_HMUL;
        end
      end
      KS_HMUL: begin
        pr_nxt = xr[59:30];
        state_nxt = KS_HREC;
      end
      KS_HREC: begin
        qm_nxt = pr_r * recip(cnt_r);
        state_nxt = KS_HFIX;
      end
      KS_HFIX: begin
        r_nxt = ONE30 - {1'b0, qf};
        if (cnt_r == 4'd1) begin
          cnt_nxt = 4'd5;
          state_nxt = KS_SQR;
        end else begin
          cnt_nxt = cnt_r - 4'd1;
          state_nxt = KS_HMUL;
        end
      end
      KS_SQR: begin
        r_nxt = rr[60:30];
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd1) begin
          state_nxt = KS_POST;
        end
      end
      KS_POST: begin
        if (cfg.mode == KM_GAUSS) begin
          kval_nxt = {22'b0, r_r[30:6]};
          state_nxt = KS_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = KS_DIVW;
        end
      end
      KS_DIVW: begin
        if (div_done) begin
          kval_nxt = {22'b0, div_q};
          state_nxt = KS_DONE;
        end
      end
      KS_DONE: state_nxt = KS_IDLE;
      default: state_nxt = KS_IDLE;
    endcase
  end

  assign done = (state_r == KS_DONE);
  assign kval = kval_r;

endmodule

// ===== rtl/core/kernel_svm_classifier.sv =====
// Load: transfers are accepted back to back while idle. Classify: for each of N support entries
// the kernel sequencer computes the kernel value (polynomial by repeated products, gaussian and
// sigmoid by Horner steps and squarings, sigmoid also by the divider); the weighted term is accumulated.
// One item is in work at a time; a finished result waits in the output register.
// Reset (synchronous, active low) clears control state and the configuration registers; the store is not
// cleared and needs no clearing pass.
module kernel_svm_classifier (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_cmd,
  input  logic [7:0]          in_entry_index,
  input  logic [9:0]          in_coord_x,
  input  logic [9:0]          in_coord_y,
  input  logic                in_label_positive,
  input  logic [30:0]         in_alpha_weight,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_class_label,
  output logic signed [47:0]  out_discriminant,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import ksvm_pkg::*;

  `include "kernel_svm_classifier_assert.svh"

  tst_t               state_r, state_nxt;
  logic [1:0]         kmode_r;
  logic [30:0]        gamma_r;
  logic [3:0]         degree_r;
  logic signed [31:0] gain_r, offset_r, bias_r;
  logic [8:0]         vcount_r;
  logic [8:0]         idx_r, idx_nxt, n_r, n_nxt;
  logic [9:0]         qx_r, qx_nxt, qy_r, qy_nxt;
  logic signed [47:0] acc_r, acc_nxt;
  logic [53:0]        phi_r, phi_nxt;
  logic [30:0]        plo_r, plo_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_class_r, out_class_nxt;
  logic signed [47:0] out_disc_r, out_disc_nxt;

  logic   in_xfer, mem_we, mem_re, k_start, k_done;
  entry_t wentry, rentry;
  kcfg_t  kcfg;
  logic [46:0] kval;

  assign in_xfer = in_valid && !in_stall;
  assign in_stall = (state_r != T_IDLE);
  assign mem_we = in_xfer && (in_cmd == CMD_LOAD);
  assign wentry = '{x: in_coord_x, y: in_coord_y, pos: in_label_positive,
                    alpha: in_alpha_weight};
  assign kcfg = '{mode: kmode_r, gamma: gamma_r, degree: degree_r, gain: gain_r,
                  offset: offset_r};

  ksvm_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (in_entry_index),
    .wdata (wentry),
    .re    (mem_re),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (rentry)
  );

  ksvm_kernel u_kernel (
    .clk   (clk),
    .rst_n (rst_n),
    .start (k_start),
    .ex    (rentry.x),
    .ey    (rentry.y),
    .qx    (qx_r),
    .qy    (qy_r),
    .cfg   (kcfg),
    .done  (k_done),
    .kval  (kval)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      out_valid_r <= 1'b0;
      kmode_r <= KM_LINEAR;
      gamma_r <= '0;
      degree_r <= '0;
      gain_r <= 32'sd16777216;
      offset_r <= '0;
      bias_r <= '0;
      vcount_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_KERNEL_MODE:    kmode_r <= cfg_data[1:0];
          REG_GAUSSIAN_GAMMA: gamma_r <= cfg_data[30:0];
          REG_POLY_DEGREE:    degree_r <= cfg_data[3:0];
          REG_SIGMOID_GAIN:   gain_r <= cfg_data;
          REG_SIGMOID_OFFSET: offset_r <= cfg_data;
          REG_BIAS_TERM:      bias_r <= cfg_data;
          REG_VECTOR_COUNT:   vcount_r <= cfg_data[8:0];
          default: ;
        endcase
      end
    end
    idx_r <= idx_nxt;
    n_r <= n_nxt;
    qx_r <= qx_nxt;
    qy_r <= qy_nxt;
    acc_r <= acc_nxt;
    phi_r <= phi_nxt;
    plo_r <= plo_nxt;
    out_class_r <= out_class_nxt;
    out_disc_r <= out_disc_nxt;
  end

  always_comb begin
    logic [8:0]         nsat;
    logic [54:0]        pl, mag;
    logic [47:0]        magsat;
    logic signed [48:0] term, sum, diff;

    state_nxt = state_r;
    idx_nxt = idx_r;
    n_nxt = n_r;
    qx_nxt = qx_r;
    qy_nxt = qy_r;
    acc_nxt = acc_r;
    phi_nxt = phi_r;
    plo_nxt = plo_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_class_nxt = out_class_r;
    out_disc_nxt = out_disc_r;
    mem_re = 1'b0;
    k_start = 1'b0;

    nsat = (vcount_r > 9'(MAX_VECTORS)) ? 9'(MAX_VECTORS) : vcount_r;
    pl = rentry.alpha * kval[23:0];
    mag = {1'b0, phi_r} + {24'b0, plo_r};
    magsat = (mag[54:47] != 8'd0) ? Q24_MAX : {1'b0, mag[46:0]};
    term = rentry.pos ? $signed({1'b0, magsat}) : -$signed({1'b0, magsat});
    sum = {acc_r[47], acc_r} + term;
    diff = {acc_r[47], acc_r} - {{17{bias_r[31]}}, bias_r};

    case (state_r)
      T_IDLE: begin
        if (in_xfer && (in_cmd == CMD_CLASSIFY)) begin
          qx_nxt = in_coord_x;
          qy_nxt = in_coord_y;
          acc_nxt = '0;
          idx_nxt = '0;
          n_nxt = nsat;
          state_nxt = (nsat == 9'd0) ? T_BIAS : T_READ;
        end
      end
      T_READ: begin
        mem_re = 1'b1;
        state_nxt = T_KSTART;
      end
      T_KSTART: begin
        k_start = 1'b1;
        state_nxt = T_KWAIT;
      end
      T_KWAIT: begin
        if (k_done) begin
          state_nxt = T_MULH;
        end
      end
      T_MULH: begin
        phi_nxt = rentry.alpha * kval[46:24];
        state_nxt = T_MULL;
      end
      T_MULL: begin
        plo_nxt = pl[54:24];
        state_nxt = T_ACC;
      end
      T_ACC: begin
        acc_nxt = sat48(sum);
        idx_nxt = idx_r + 9'd1;
        state_nxt = (idx_r + 9'd1 == n_r) ? T_BIAS : T_READ;
      end
      T_BIAS: begin
        acc_nxt = sat48(diff);
        state_nxt = T_OUT;
      end
      T_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_class_nxt = acc_r[47];
          out_disc_nxt = acc_r;
          state_nxt = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_class_label = out_class_r;
  assign out_discriminant = out_disc_r;

  `KSVM_ASSERT_NOW(a_read_in_range, clk, rst_n, state_r == T_READ, idx_r < n_r)
  `KSVM_ASSERT_NOW(a_kdone_awaited, clk, rst_n, k_done, state_r == T_KWAIT)
  `KSVM_ASSERT_NOW(a_class_sign, clk, rst_n, out_valid_r, out_class_label == out_discriminant[47])
  `KSVM_ASSERT_NEXT(a_classify_busy, clk, rst_n, in_xfer && in_cmd == CMD_CLASSIFY, state_r != T_IDLE)

endmodule

// ===== test/tb_kernel_svm_classifier.sv =====
// Self-checking testbench for kernel_svm_classifier: loads support entries, classifies
// query points in all kernel modes, and checks each result against an internal predictor.
// Depends on ksvm_pkg and the kernel_svm_classifier RTL.
module tb_kernel_svm_classifier;
  timeunit 1ns;
  timeprecision 1ps;
  import ksvm_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam longint DISC_HI = 64'sd140737488355327;
  localparam longint DISC_LO = -64'sd140737488355328;
  localparam longint unsigned Q30_ONE = 64'd1 << 30;
  localparam longint unsigned POW_CAP = 64'd8388607;
  localparam int STALL_LIMIT = 300000;

  typedef struct {
    logic        cls;
    logic [47:0] disc;
  } verdict_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_cmd = CMD_LOAD;
  logic [7:0]         in_entry_index = '0;
  logic [9:0]         in_coord_x = '0;
  logic [9:0]         in_coord_y = '0;
  logic               in_label_positive = 1'b0;
  logic [30:0]        in_alpha_weight = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_class_label;
  logic signed [47:0] out_discriminant;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  entry_t          support_copy[MAX_VECTORS];
  logic [1:0]      mode_r;
  longint unsigned gamma_r;
  int unsigned     degree_r;
  longint          gain_r;
  longint          offset_r;
  longint          bias_r;
  int unsigned     count_r;

  verdict_t pending_verdicts[$];
  int       errors = 0;
  bit       idle_en = 1'b1;
  int       quiet_cycles = 0;

  kernel_svm_classifier u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned exp_neg_q30(longint unsigned t);
    longint unsigned x, r;
    if (t >= (64'd17 << 24)) return 0;
    x = t << 1;
    r = Q30_ONE;
    for (int k = 10; k >= 1; k--) r = Q30_ONE - ((x * r) >> 30) / longint'(k);
    for (int k = 0; k < 5; k++) r = (r * r) >> 30;
    return r;
  endfunction

  function automatic longint unsigned kernel_q24(entry_t e, int unsigned qx, int unsigned qy);
    longint unsigned dot, p, e_val;
    longint dx, dy, u;
    dot = longint'(e.x) * qx + longint'(e.y) * qy;
    case (mode_r)
      KM_POLY: begin
        p = dot;
        for (int unsigned i = 1; i < degree_r; i++) begin
          p = p * dot;
          if (p > POW_CAP) return DISC_HI;
        end
        return p << 24;
      end
      KM_GAUSS: begin
        dx = longint'(e.x) - longint'(qx);
        dy = longint'(e.y) - longint'(qy);
        return exp_neg_q30(gamma_r * longint'(dx * dx + dy * dy)) >> 6;
      end
      KM_SIGMOID: begin
        u = gain_r * longint'(dot) + offset_r;
        if (u >= 0) begin
          e_val = exp_neg_q30(u);
          return (e_val << 24) / (Q30_ONE + e_val);
        end
        e_val = exp_neg_q30(-u);
        return (Q30_ONE << 24) / (Q30_ONE + e_val);
      end
      default: return dot << 24;
    endcase
  endfunction

  function automatic longint clamp48(longint v);
    if (v > DISC_HI) return DISC_HI;
    if (v < DISC_LO) return DISC_LO;
    return v;
  endfunction

  function automatic longint decision_sum(int unsigned qx, int unsigned qy);
    longint unsigned kv, a, mag;
    longint acc;
    int unsigned n;
    acc = 0;
    n = (count_r > MAX_VECTORS) ? MAX_VECTORS : count_r;
    for (int unsigned i = 0; i < n; i++) begin
      kv = kernel_q24(support_copy[i], qx, qy);
      a = support_copy[i].alpha;
      mag = a * (kv >> 24) + ((a * (kv & 64'hFFFFFF)) >> 24);
      if (mag > DISC_HI) mag = DISC_HI;
      acc = clamp48(acc + (support_copy[i].pos ? longint'(mag) : -longint'(mag)));
    end
    return clamp48(acc - bias_r);
  endfunction

  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_KERNEL_MODE:    mode_r = data[1:0];
      REG_GAUSSIAN_GAMMA: gamma_r = data[30:0];
      REG_POLY_DEGREE:    degree_r = data[3:0];
      REG_SIGMOID_GAIN:   gain_r = longint'(signed'(data));
      REG_SIGMOID_OFFSET: offset_r = longint'(signed'(data));
      REG_BIAS_TERM:      bias_r = longint'(signed'(data));
      REG_VECTOR_COUNT:   count_r = data[8:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_config(logic [1:0] mode, logic [31:0] gamma, logic [31:0] degree,
                            logic [31:0] gain, logic [31:0] offset, logic [31:0] bias,
                            logic [31:0] count);
    drain();
    cfg_write(REG_KERNEL_MODE, {30'd0, mode});
    cfg_write(REG_GAUSSIAN_GAMMA, gamma);
    cfg_write(REG_POLY_DEGREE, degree);
    cfg_write(REG_SIGMOID_GAIN, gain);
    cfg_write(REG_SIGMOID_OFFSET, offset);
    cfg_write(REG_BIAS_TERM, bias);
    cfg_write(REG_VECTOR_COUNT, count);
    cfg_write(REG_UNUSED, $urandom);
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(logic cmd, logic [7:0] idx, logic [9:0] x, logic [9:0] y,
                           logic pos, logic [30:0] alpha);
    verdict_t v;
    longint d;
    if (idle_en && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_entry_index <= idx;
    in_coord_x <= x;
    in_coord_y <= y;
    in_label_positive <= pos;
    in_alpha_weight <= alpha;
    do @(posedge clk); while (in_stall);
    if (cmd == CMD_LOAD) begin
      support_copy[idx] = '{x: x, y: y, pos: pos, alpha: alpha};
    end else begin
      d = decision_sum(x, y);
      v.cls = d < 0;
      v.disc = d[47:0];
      pending_verdicts.push_back(v);
    end
  endtask

  task automatic classify(logic [9:0] x, logic [9:0] y);
    send_item(CMD_CLASSIFY, 8'($urandom), x, y, 1'($urandom), 31'($urandom));
  endtask

  function automatic logic [30:0] rand_alpha();
    return 31'($urandom >> $urandom_range(0, 31));
  endfunction

  function automatic logic [31:0] rand_signed();
    return 32'(int'($urandom) >>> $urandom_range(0, 31));
  endfunction

  always @(posedge clk) begin
    out_stall <= idle_en && ($urandom_range(0, 99) < 13);
  end

  always @(posedge clk) begin
    verdict_t v;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result class=%0b disc=%0d", $time, out_class_label,
                 out_discriminant);
        errors++;
      end else begin
        v = pending_verdicts.pop_front();
        if (out_class_label !== v.cls || out_discriminant !== v.disc) begin
          $display("%0t: mismatch expected class=%0b disc=%0d, actual class=%0b disc=%0d",
                   $time, v.cls, signed'(v.disc), out_class_label, out_discriminant);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_reset_defaults();
    mode_r = KM_LINEAR;
    gamma_r = 0;
    degree_r = 0;
    gain_r = 16777216;
    offset_r = 0;
    bias_r = 0;
    count_r = 0;
    classify(10'd5, 10'd5);
  endtask

  task automatic test_store_fill();
    send_item(CMD_LOAD, 8'd0, 10'd1023, 10'd1023, 1'b1, 31'h7FFF_FFFF);
    send_item(CMD_LOAD, 8'd1, 10'd0, 10'd0, 1'b0, 31'd0);
    send_item(CMD_LOAD, 8'd2, 10'd1023, 10'd0, 1'b0, 31'h7FFF_FFFF);
    for (int i = 3; i < MAX_VECTORS; i++) begin
      send_item(CMD_LOAD, 8'(i), 10'($urandom), 10'($urandom), 1'($urandom), rand_alpha());
    end
  endtask

  task automatic test_zero_count();
    set_config(KM_LINEAR, 0, 0, 32'd16777216, 0, 32'h7FFF_FFFF, 0);
    classify(10'd100, 10'd200);
    set_config(KM_LINEAR, 0, 0, 32'd16777216, 0, 32'h8000_0000, 0);
    classify(10'd1023, 10'd0);
  endtask

  task automatic test_linear_poly();
    set_config(KM_LINEAR, 0, 0, 32'd16777216, 0, 0, 8);
    classify(10'd0, 10'd0);
    classify(10'd1023, 10'd1023);
    set_config(KM_POLY, 0, 0, 0, 0, 32'd5000, 8);
    classify(10'd3, 10'd7);
    set_config(KM_POLY, 0, 2, 0, 0, 0, 8);
    classify(10'd1023, 10'd1023);
    set_config(KM_POLY, 0, 15, 0, 0, 0, 8);
    classify(10'd3, 10'd1);
  endtask

  task automatic test_gaussian();
    set_config(KM_GAUSS, 0, 0, 0, 0, 0, 8);
    classify(10'd1023, 10'd0);
    set_config(KM_GAUSS, 32'h7FFF_FFFF, 0, 0, 0, 0, 8);
    classify(10'd512, 10'd512);
    set_config(KM_GAUSS, 32'd1 << 20, 0, 0, 0, 32'hFFFF_0000, 8);
    classify(support_copy[3].x, support_copy[3].y);
  endtask

  task automatic test_sigmoid();
    set_config(KM_SIGMOID, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 4);
    classify(10'd1023, 10'd1023);
    set_config(KM_SIGMOID, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 4);
    classify(10'd0, 10'd0);
    set_config(KM_SIGMOID, 0, 0, 0, 0, 32'd1, 4);
    classify(10'd77, 10'd900);
  endtask

  task automatic test_count_limits();
    set_config(KM_LINEAR, 0, 0, 0, 0, 0, 256);
    classify(10'd311, 10'd42);
    set_config(KM_LINEAR, 0, 0, 0, 0, 0, 511);
    classify(10'd1, 10'd1023);
    set_config(KM_SIGMOID, 0, 0, 32'd4096, 32'hFF00_0000, 0, 256);
    classify(10'd20, 10'd30);
  endtask

  task automatic test_random_mix();
    logic [1:0] mode;
    logic [31:0] count;
    for (int phase = 0; phase < 9; phase++) begin
      mode = 2'($urandom);
      count = $urandom_range(0, 24);
      if ($urandom_range(0, 9) == 0) begin
        mode = KM_LINEAR;
        count = $urandom_range(64, 511);
      end
      set_config(mode, $urandom >> $urandom_range(0, 31), $urandom_range(0, 15),
                 rand_signed(), rand_signed(), rand_signed(), count);
      idle_en = (phase != 3);
      for (int i = 0; i < 20; i++) begin
        if (phase == 5 && i == 10) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending_verdicts.size() != 0) @(posedge clk);
        end
        if ($urandom_range(0, 9) < 4) begin
          send_item(CMD_LOAD, 8'($urandom), 10'($urandom), 10'($urandom), 1'($urandom),
                    rand_alpha());
        end else begin
          classify(10'($urandom), 10'($urandom));
        end
      end
      idle_en = 1'b1;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_store_fill();
    test_zero_count();
    test_linear_poly();
    test_gaussian();
    test_sigmoid();
    test_count_limits();
    test_random_mix();
    drain();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
